FILE: hdl/pbar_pkg.sv
// ----------------------------------------------------------------------------
// pbar_pkg: shared definitions for the prioritised button auto-repeat block
// Defaults, register map, configuration struct and the repeat window.
// ----------------------------------------------------------------------------
package pbar_pkg;

    localparam int NUM_BUTTONS_DEF = 9;
    localparam int TIME_WIDTH_DEF  = 32;

    // configuration registers are 16 bits wide on a 32-bit APB data bus
    localparam int CFG_W  = 16;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CFG_W-1:0] DELAY_RST     = 16'd500;
    localparam logic [CFG_W-1:0] INTERVAL_RST  = 16'd100;
    localparam logic [CFG_W-1:0] REPEAT_WINDOW = 16'd20;

    // register index, taken from paddr[2]
    localparam logic REG_DELAY    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] interval;
    } t_cfg;

endpackage

FILE: hdl/pbar_if.sv
// ----------------------------------------------------------------------------
// pbar_if: item channels of the button auto-repeat block
// Poll channel (flag, pressed vector, timestamp) and event channel.
// ----------------------------------------------------------------------------
interface pbar_in_if
    import pbar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic                   device_available;
    logic [NUM_BUTTONS-1:0] pressed_mask;
    logic [TIME_WIDTH-1:0]  now_ms;

    modport source (output valid, device_available, pressed_mask, now_ms, input ready);
    modport sink   (input valid, device_available, pressed_mask, now_ms, output ready);
endinterface

interface pbar_out_if
    import pbar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) ();
    logic                               valid;
    logic                               ready;
    logic [$clog2(NUM_BUTTONS+1)-1:0]   event_code;

    modport source (output valid, event_code, input ready);
    modport sink   (input valid, event_code, output ready);
endinterface

FILE: hdl/prioritized_button_autorepeat.sv
// ----------------------------------------------------------------------------
// prioritized_button_autorepeat: typematic repeat over a prioritised scan
// Scans buttons in fixed order, one press-time memory entry per button.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  i_in    | in        | valid / ready      | device_available, pressed_mask, now_ms
//  o_out   | out       | valid / ready      | event_code
//  APB     | in        | psel/penable/pready| repeat_delay @0x0, repeat_interval @0x4
//
//  The time spent on one poll item is set by the bit-serial remainder unit,
//  which runs once for each repeating button that the scan reaches, and by the
//  registered read of the press-time memory that comes before each button.
//  Synchronous active-low reset clears the held and repeat flags at once; no
//  clearing pass is needed. A finished event waits in the output register
//  while the next poll item is taken; the scan holds only when that register
//  is still full at the end of the following item.
// ----------------------------------------------------------------------------
module prioritized_button_autorepeat
    import pbar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbar_in_if.sink           i_in,
    pbar_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam int BTN_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CODE_W = $clog2(NUM_BUTTONS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,  // wait for a poll item
        S_RD   = 6'b000010,  // memory read of the current button in flight
        S_EVAL = 6'b000100,  // release / fresh press handling
        S_CHK  = 6'b001000,  // delay check, launch the remainder
        S_DIV  = 6'b010000,  // wait for the remainder
        S_OUT  = 6'b100000   // hand the event to the output register
    } t_state;

    t_state                 r_state, n_state;
    logic [BTN_W-1:0]       r_btn, n_btn;
    logic [CODE_W-1:0]      r_code, n_code;
    logic [NUM_BUTTONS-1:0] r_mask;
    logic [TIME_WIDTH-1:0]  r_now;
    logic                   r_avail;
    logic [TIME_WIDTH-1:0]  r_held;
    logic [NUM_BUTTONS-1:0] r_held_vld;
    logic [NUM_BUTTONS-1:0] r_rep;
    logic                   r_out_valid;
    logic [CODE_W-1:0]      r_out_code;

    // press-time memory, one entry per button
    logic [TIME_WIDTH-1:0]  r_mem [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0]  r_rd_data;

    t_cfg                   w_cfg;
    logic                   w_accept;
    logic                   w_we;
    logic                   w_set_vld;
    logic                   w_clr;
    logic                   w_set_rep;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [CFG_W-1:0]       w_rem;
    logic [CFG_W-1:0]       w_period;
    logic [TIME_WIDTH-1:0]  w_delay;
    logic [TIME_WIDTH-1:0]  w_since;
    logic                   w_load_out;
    logic                   w_last;

    pbar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // a zero interval acts as one, so a repeating button fires on every poll whose scan reaches it
    assign w_period = (w_cfg.interval == '0) ? CFG_W'(1) : w_cfg.interval;
    assign w_delay  = TIME_WIDTH'(w_cfg.delay);
    assign w_since  = r_held - w_delay;

    pbar_mod #(.DW(TIME_WIDTH)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_since),
        .i_divisor  (w_period),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign w_accept         = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.event_code = r_out_code;
    assign w_last           = (r_btn == BTN_W'(NUM_BUTTONS - 1));

    // scan sequencer
    always_comb begin
        n_state     = r_state;
        n_btn       = r_btn;
        n_code      = r_code;
        w_we        = 1'b0;
        w_set_vld   = 1'b0;
        w_clr       = 1'b0;
        w_set_rep   = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_btn   = '0;
                    n_code  = '0;
                    // unavailable device: no event, no update
                    n_state = i_in.device_available ? S_RD : S_OUT;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!r_mask[r_btn]) begin
                    // released: drop hold and repeat, move on
                    w_clr = 1'b1;
                    if (w_last) begin
                        n_state = S_OUT;
                    end else begin
                        n_btn   = r_btn + BTN_W'(1);
                        n_state = S_RD;
                    end
                end else if (!r_held_vld[r_btn]) begin
                    // fresh press: record time and fire
                    w_we      = 1'b1;
                    w_set_vld = 1'b1;
                    n_code    = CODE_W'(r_btn) + CODE_W'(1);
                    n_state   = S_OUT;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!r_rep[r_btn] && (r_held >= w_delay)) begin
                    w_set_rep = 1'b1;
                    n_code    = CODE_W'(r_btn) + CODE_W'(1);
                    n_state   = S_OUT;
                end else if (r_rep[r_btn]) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else if (w_last) begin
                    n_state = S_OUT;
                end else begin
                    n_btn   = r_btn + BTN_W'(1);
                    n_state = S_RD;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_rem < REPEAT_WINDOW) begin
                        n_code  = CODE_W'(r_btn) + CODE_W'(1);
                        n_state = S_OUT;
                    end else if (w_last) begin
                        n_state = S_OUT;
                    end else begin
                        n_btn   = r_btn + BTN_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held_vld  <= '0;
            r_rep       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clr) begin
                r_held_vld[r_btn] <= 1'b0;
                r_rep[r_btn]      <= 1'b0;
            end
            if (w_set_vld) begin
                r_held_vld[r_btn] <= 1'b1;
            end
            if (w_set_rep) begin
                r_rep[r_btn] <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_btn  <= n_btn;
        r_code <= n_code;
        // held time, modulo 2^TIME_WIDTH
        r_held <= r_now - r_rd_data;
        if (w_accept) begin
            r_mask  <= i_in.pressed_mask;
            r_now   <= i_in.now_ms;
            r_avail <= i_in.device_available;
        end
        if (w_load_out) begin
            r_out_code <= r_code;
        end
    end

    // press-time memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_btn] <= r_now;
        end
        r_rd_data <= r_mem[r_btn];
    end

    // repeat mode only ever exists on a recorded press
    a_rep_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rep & ~r_held_vld) == '0)
        else $error("repeat flag set on a button with no recorded press");

    // an unavailable device always yields the empty event
    a_unavail_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && !r_avail) |-> (r_code == '0))
        else $error("event raised for an unavailable device");

    // a released button loses its hold state
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && !r_mask[r_btn]) |=> !r_held_vld[$past(r_btn)])
        else $error("released button still marked as held");

    // the remainder unit only reports while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("remainder finished outside its wait state");

    // event codes stay within the button range
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code <= CODE_W'(NUM_BUTTONS)))
        else $error("event code beyond the last button");
endmodule

FILE: hdl/pbar_cfg.sv
// ----------------------------------------------------------------------------
// pbar_cfg: APB register file
// Holds repeat delay and repeat interval; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module pbar_cfg
    import pbar_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay    <= DELAY_RST;
            r_cfg.interval <= INTERVAL_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_DELAY:    r_cfg.delay    <= pwdata[CFG_W-1:0];
                REG_INTERVAL: r_cfg.interval <= pwdata[CFG_W-1:0];
                default:      r_cfg.delay    <= r_cfg.delay;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DELAY:    prdata = APB_DW'(r_cfg.delay);
            REG_INTERVAL: prdata = APB_DW'(r_cfg.interval);
            default:      prdata = '0;
        endcase
    end
endmodule

FILE: hdl/pbar_mod.sv
// ----------------------------------------------------------------------------
// pbar_mod: iterative remainder unit
// Restoring division, one dividend bit per cycle; yields the remainder only.
// ----------------------------------------------------------------------------
module pbar_mod
    import pbar_pkg::*;
#(
    parameter int DW = TIME_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [CFG_W-1:0] i_divisor,
    output logic             o_done,
    output logic [CFG_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_dvd;
    logic [CFG_W-1:0] r_rem;
    logic [CFG_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CFG_W:0]   w_trial;
    logic [CFG_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= CNT_W'(DW);
        end else if (r_busy) begin
            // keep the difference when the trial value covers the divisor
            r_rem <= w_diff[CFG_W] ? w_trial[CFG_W-1:0] : w_diff[CFG_W-1:0];
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

FILE: tb/prioritized_button_autorepeat_tb.sv
// ----------------------------------------------------------------------------
// prioritized_button_autorepeat_tb: self-checking bench for the auto-repeat block
// Polls go in through a random sender and events come out to a random receiver.
// A local copy of the per-button hold and repeat state works out each event
// code that the directed table does not pin, and every event is checked in
// order. That table opens the run. Random phases follow, each under its own
// delay and interval, one of four idling modes; one has a long receiver hold-off.
// ----------------------------------------------------------------------------
module prioritized_button_autorepeat_tb
    import pbar_pkg::*;
();

    localparam int NB              = NUM_BUTTONS_DEF;
    localparam int NO_PIN          = -1;     // directed row is checked by the tracker
    localparam int ITEMS_PER_PHASE = 86;
    localparam int NUM_PHASES      = 8;
    localparam int LONG_HOLD       = 1500;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES    = 400;    // beyond the worst scan
    localparam int WATCHDOG_LIMIT  = 20000;

    typedef enum logic [3:0] {
        EVT_NONE, EVT_UP, EVT_DOWN, EVT_LEFT, EVT_RIGHT,
        EVT_CONFIRM, EVT_CANCEL, EVT_MENU, EVT_START, EVT_SELECT
    } t_button_event;

    typedef struct {
        logic        avail;
        logic [8:0]  mask;
        logic [31:0] now;
        int          code;   // event code read straight off the row, or NO_PIN
    } t_poll_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pbar_in_if  poll_if ();
    pbar_out_if event_if ();

    prioritized_button_autorepeat DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (poll_if),
        .o_out   (event_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Tracked button state and the register copies it runs under
    logic [31:0]      press_time [NB];
    logic             press_held [NB];
    logic             repeating  [NB];
    logic [CFG_W-1:0] delay_cfg;
    logic [CFG_W-1:0] interval_cfg;

    logic [3:0] codes_due [$];      // event codes still owed by the block
    int         pinned_codes [$];   // one per offered poll, NO_PIN for most
    int         fail_count;
    int         idle_pct;           // sender: chance of a gap cycle, in percent
    int         stall_pct;          // receiver: chance of a stall cycle, in percent
    int         hold_requests;      // bumped by the stimulus to ask for a long hold-off
    int         quiet_cycles;

    // Reset config on the directed run: delay 500, interval 100.
    // Covers the unavailable device, a press at time zero, priority order,
    // first repeat at the delay, repeat windows, release and time wrap.
    t_poll_row directed_polls [21] = '{
        '{1'b0, 9'h1FF, 32'hFFFF_FFFF, EVT_NONE},
        '{1'b1, 9'h000, 32'h0000_0000, EVT_NONE},
        '{1'b1, 9'h001, 32'h0000_0000, EVT_UP},
        '{1'b1, 9'h001, 32'd10,        NO_PIN},
        '{1'b1, 9'h003, 32'd20,        NO_PIN},
        '{1'b1, 9'h003, 32'd500,       NO_PIN},
        '{1'b1, 9'h003, 32'd510,       NO_PIN},
        '{1'b1, 9'h003, 32'd550,       NO_PIN},
        '{1'b1, 9'h003, 32'd600,       NO_PIN},
        '{1'b0, 9'h000, 32'h0000_0000, EVT_NONE},
        '{1'b1, 9'h1FF, 32'd650,       NO_PIN},
        '{1'b1, 9'h1F8, 32'd651,       NO_PIN},
        '{1'b1, 9'h100, 32'd652,       NO_PIN},
        '{1'b1, 9'h000, 32'h0000_0000, EVT_NONE},
        '{1'b1, 9'h100, 32'hFFFF_FF00, EVT_SELECT},
        '{1'b1, 9'h100, 32'h0000_00F4, NO_PIN},
        '{1'b1, 9'h100, 32'h0000_0108, NO_PIN},
        '{1'b1, 9'h100, 32'h0000_0158, NO_PIN},
        '{1'b1, 9'h1FF, 32'hFFFF_FFFF, NO_PIN},
        '{1'b1, 9'h0AA, 32'h7FFF_FFFF, NO_PIN},
        '{1'b1, 9'h155, 32'h8000_0000, NO_PIN}
    };

    // Delay and interval per random phase; extremes and a zero interval included
    t_cfg phase_cfgs [NUM_PHASES] = '{
        '{16'd500,   16'd100},
        '{16'd0,     16'd1},
        '{16'd65535, 16'd65535},
        '{16'd0,     16'd0},
        '{16'd7,     16'd3},
        '{16'd200,   16'd50},
        '{16'd1,     16'd65535},
        '{16'd65535, 16'd1}
    };

    // Scan the buttons in priority order and advance the tracked state;
    // the first button to fire ends the scan and leaves the rest alone.
    function automatic logic [3:0] predict_event(input logic avail, input logic [8:0] mask,
                                                 input logic [31:0] now);
        logic [31:0] held;
        logic [31:0] since;
        logic [31:0] period;
        logic [3:0]  code;
        code = EVT_NONE;
        if (!avail) return code;    // unavailable device: touch nothing
        for (int b = 0; b < NB; b++) begin
            if (!mask[b]) begin
                press_time[b] = '0;
                press_held[b] = 1'b0;
                repeating[b]  = 1'b0;
            end else if (!press_held[b]) begin
                // fresh press, time zero included
                press_time[b] = now;
                press_held[b] = 1'b1;
                code = 4'(b + 1);
                break;
            end else begin
                held = now - press_time[b];     // wraps with the timestamp
                if (!repeating[b] && held >= 32'(delay_cfg)) begin
                    repeating[b] = 1'b1;
                    code = 4'(b + 1);
                    break;
                end else if (repeating[b]) begin
                    since  = held - 32'(delay_cfg);
                    period = (interval_cfg == '0) ? 32'd1 : 32'(interval_cfg);
                    if (since % period < 32'(REPEAT_WINDOW)) begin
                        code = 4'(b + 1);
                        break;
                    end
                end
            end
        end
        return code;
    endfunction

    // APB write with setup and access phases; the register lands at the access edge
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DELAY) delay_cfg = value;
        else                  interval_cfg = value;
    endtask

    // Offer one poll and hold it until the block takes it
    task automatic offer_poll(input logic avail, input logic [8:0] mask,
                              input logic [31:0] now, input int pin);
        while ($urandom_range(0, 99) < idle_pct) begin
            poll_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pinned_codes.push_back(pin);
        poll_if.valid            <= 1'b1;
        poll_if.device_available <= avail;
        poll_if.pressed_mask     <= mask;
        poll_if.now_ms           <= now;
        do @(posedge i_clk); while (!poll_if.ready);
    endtask

    // Mostly plausible hold sequences: a few buttons toggle, time creeps on
    // in small steps with some jumps around the delay and interval. The rest
    // is noise: unavailable polls, random masks and random timestamps.
    task automatic run_phase(input int n);
        int          done;
        int          r;
        logic        avail;
        logic [8:0]  cur_mask;
        logic [31:0] cur_now;
        logic [8:0]  m;
        logic [31:0] t;
        done     = 0;
        cur_mask = 9'($urandom);
        cur_now  = $urandom;
        while (done < n) begin
            r     = $urandom_range(0, 99);
            avail = 1'b1;
            if (r < 6) begin
                avail = 1'b0;
                m = 9'($urandom);
                t = $urandom;
            end else if (r < 12) begin
                cur_mask = 9'($urandom);
                cur_now  = $urandom;
                m = cur_mask;
                t = cur_now;
            end else begin
                if (r < 18) begin
                    // lone button so the low-priority ones get to repeat
                    cur_mask = 9'(1) << $urandom_range(0, NB - 1);
                end else begin
                    for (int b = 0; b < NB; b++)
                        if ($urandom_range(0, 11) == 0) cur_mask[b] = ~cur_mask[b];
                end
                r = $urandom_range(0, 99);
                if (r < 15)      cur_now += $urandom_range(0, delay_cfg);
                else if (r < 25) cur_now += $urandom_range(0, 32'(interval_cfg) + 20);
                else             cur_now += $urandom_range(0, 25);
                m = cur_mask;
                t = cur_now;
            end
            offer_poll(avail, m, t, NO_PIN);
            if (avail) done++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        event_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != hold_requests) begin
                served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                event_if.ready <= 1'b0;
            end else begin
                event_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Track accepted polls, check accepted events, and watch for a hang
    always @(posedge i_clk) begin
        logic [3:0] code;
        logic [3:0] want;
        int         pin;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (poll_if.valid && poll_if.ready) begin
                code = predict_event(poll_if.device_available, poll_if.pressed_mask,
                                     poll_if.now_ms);
                pin  = pinned_codes.pop_front();
                if (pin != NO_PIN) code = 4'(pin);
                codes_due.push_back(code);
            end
            if (event_if.valid && event_if.ready) begin
                if (codes_due.size() == 0) begin
                    $error("event_code: expected nothing, actual %0d", event_if.event_code);
                    fail_count++;
                end else begin
                    want = codes_due.pop_front();
                    if (event_if.event_code !== want) begin
                        $error("event_code: expected %0d, actual %0d",
                               want, event_if.event_code);
                        fail_count++;
                    end
                end
            end
            if ((poll_if.valid && poll_if.ready) || (event_if.valid && event_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("prioritized_button_autorepeat verification failed");
                $finish;
            end
        end
    end

    initial begin
        fail_count    = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        delay_cfg     = DELAY_RST;
        interval_cfg  = INTERVAL_RST;
        for (int b = 0; b < NB; b++) begin
            press_time[b] = '0;
            press_held[b] = 1'b0;
            repeating[b]  = 1'b0;
        end
        i_rst_n                  <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        poll_if.valid            <= 1'b0;
        poll_if.device_available <= 1'b0;
        poll_if.pressed_mask     <= '0;
        poll_if.now_ms           <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset config, no idling
        foreach (directed_polls[i])
            offer_poll(directed_polls[i].avail, directed_polls[i].mask,
                       directed_polls[i].now, directed_polls[i].code);
        poll_if.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Drain before touching the registers; every poll yields one event.
            // Let the clock advance first so the last accepted poll is on the queue.
            @(posedge i_clk);
            while (codes_due.size() != 0) @(posedge i_clk);
            write_reg(REG_DELAY, phase_cfgs[p].delay);
            write_reg(REG_INTERVAL, phase_cfgs[p].interval);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            // Hold the receiver off while polls keep coming, to fill the block
            if (p == 4) hold_requests++;
            run_phase(ITEMS_PER_PHASE);
            poll_if.valid <= 1'b0;
        end

        stall_pct = 0;
        @(posedge i_clk);
        while (codes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("prioritized_button_autorepeat verification clean");
        else
            $display("prioritized_button_autorepeat verification failed");
        $finish;
    end

endmodule
